@@ src/mtt_pkg.sv @@
`timescale 1ns / 1ps

package mtt_pkg;

  // Request codes carried on the request type field.
  typedef enum logic [2:0] {
    REQ_ADD    = 3'd0,
    REQ_CANCEL = 3'd1,
    REQ_PAUSE  = 3'd2,
    REQ_RESUME = 3'd3,
    REQ_TICK   = 3'd4
  } mtt_req_t;

  // Result kinds.
  localparam logic KIND_REPLY  = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned TIME_W = 32;

  // First id handed out, and the value the id counter wraps to.
  localparam logic [ID_W-1:0] ID_FIRST = 16'd1;
  localparam logic [ID_W-1:0] ID_NONE  = 16'd0;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_FLUSH = 2'd2,
    ST_REPLY = 2'd3
  } mtt_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic rd_en;    // read the slot memories at the read index
    logic eval;     // evaluate the slot at the evaluation index
    logic reply;    // emit the closing result of the item
  } mtt_cmd_t;

endpackage

@@ src/mtt_ctrl.sv @@
`timescale 1ns / 1ps

module mtt_ctrl #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned IW    = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output mtt_pkg::mtt_cmd_t  cmd,
  output logic [IW-1:0]      rd_idx,
  output logic [IW-1:0]      ev_idx
);

  import mtt_pkg::*;

  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  mtt_state_t    state_r, state_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] ev_idx_r, ev_idx_nxt;
  logic          ev_valid_r, ev_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      ev_idx_r   <= '0;
      ev_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      ev_idx_r   <= ev_idx_nxt;
      ev_valid_r <= ev_valid_nxt;
    end
  end

  // Next state: the scan reads one slot per cycle and evaluates the slot
  // read in the cycle before.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    ev_idx_nxt   = ev_idx_r;
    ev_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ev_valid_nxt = 1'b1;
        ev_idx_nxt   = cnt_r;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_REPLY;
      end
      ST_REPLY: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    busy        = (state_r != ST_IDLE);
    cmd.capture = (state_r == ST_IDLE) && start;
    cmd.rd_en   = (state_r == ST_SCAN);
    cmd.eval    = ev_valid_r;
    cmd.reply   = (state_r == ST_REPLY);
    rd_idx      = cnt_r;
    ev_idx      = ev_idx_r;
  end

endmodule

@@ src/mtt_dpath.sv @@
`timescale 1ns / 1ps

module mtt_dpath #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned IW    = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mtt_pkg::mtt_cmd_t             cmd,
  input  logic [IW-1:0]                 rd_idx,
  input  logic [IW-1:0]                 ev_idx,
  input  logic [2:0]                    in_req_type,
  input  logic [mtt_pkg::TIME_W-1:0]    in_now_ms,
  input  logic [mtt_pkg::TIME_W-1:0]    in_interval_ms,
  input  logic                          in_repeat_mode,
  input  logic                          in_has_action,
  input  logic [mtt_pkg::ID_W-1:0]      in_timer_id,
  output logic                          out_valid,
  output logic                          out_result_kind,
  output logic [mtt_pkg::ID_W-1:0]      out_result_id,
  output logic                          out_last
);

  import mtt_pkg::*;

  // Captured item.
  mtt_req_t          req_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] ival_r;
  logic              rep_r;
  logic              act_r;
  logic [ID_W-1:0]   tid_r;

  // Per-slot flags in flip-flops.
  logic [SLOTS-1:0] active_r, active_nxt;
  logic [SLOTS-1:0] armed_r, armed_nxt;
  logic [SLOTS-1:0] repeat_r, repeat_nxt;
  logic [SLOTS-1:0] written_r, written_nxt;

  // Slot memories and their registered read data.
  logic [TIME_W-1:0] ival_mem  [SLOTS];
  logic [TIME_W-1:0] start_mem [SLOTS];
  logic [ID_W-1:0]   ident_mem [SLOTS];
  logic [TIME_W-1:0] ival_q;
  logic [TIME_W-1:0] start_q;
  logic [ID_W-1:0]   ident_q;

  logic [ID_W-1:0] nid_r, nid_nxt;
  logic [ID_W-1:0] got_r, got_nxt;
  logic            done_r, done_nxt;

  logic              we_add;
  logic              we_start;
  logic              expire;
  logic [ID_W-1:0]   cur_ident;
  logic [TIME_W-1:0] elapsed;
  logic              due;
  logic              cur_active;
  logic              cur_armed;
  logic              cur_repeat;
  logic              id_match;

  logic            out_valid_r, out_valid_nxt;
  logic            out_kind_r, out_kind_nxt;
  logic [ID_W-1:0] out_id_r, out_id_nxt;
  logic            out_last_r, out_last_nxt;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= mtt_req_t'(in_req_type);
      now_r  <= in_now_ms;
      ival_r <= in_interval_ms;
      rep_r  <= in_repeat_mode;
      act_r  <= in_has_action;
      tid_r  <= in_timer_id;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      ival_q  <= ival_mem[rd_idx];
      start_q <= start_mem[rd_idx];
      ident_q <= ident_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (we_add) begin
      ival_mem[ev_idx]  <= ival_r;
      ident_mem[ev_idx] <= nid_r;
    end
    if (we_add || we_start) begin
      start_mem[ev_idx] <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      armed_r     <= '0;
      repeat_r    <= '0;
      written_r   <= '0;
      nid_r       <= ID_FIRST;
      got_r       <= ID_NONE;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      armed_r     <= armed_nxt;
      repeat_r    <= repeat_nxt;
      written_r   <= written_nxt;
      nid_r       <= nid_nxt;
      got_r       <= got_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

  // A slot whose id was never written reads as id zero.
  assign cur_ident  = written_r[ev_idx] ? ident_q : ID_NONE;
  assign cur_active = active_r[ev_idx];
  assign cur_armed  = armed_r[ev_idx];
  assign cur_repeat = repeat_r[ev_idx];
  assign id_match   = (cur_ident == tid_r);
  assign elapsed    = now_r - start_q;
  assign due        = (elapsed >= ival_q);

  always_comb begin
    active_nxt  = active_r;
    armed_nxt   = armed_r;
    repeat_nxt  = repeat_r;
    written_nxt = written_r;
    nid_nxt     = nid_r;
    got_nxt     = got_r;
    done_nxt    = done_r;
    we_add      = 1'b0;
    we_start    = 1'b0;
    expire      = 1'b0;
    if (cmd.capture) begin
      got_nxt  = ID_NONE;
      done_nxt = 1'b0;
    end else if (cmd.eval) begin
      case (req_r)
        REQ_ADD: begin
          if (!done_r && !cur_active) begin
            active_nxt[ev_idx]  = 1'b1;
            armed_nxt[ev_idx]   = act_r;
            repeat_nxt[ev_idx]  = rep_r;
            written_nxt[ev_idx] = 1'b1;
            we_add              = 1'b1;
            got_nxt             = nid_r;
            done_nxt            = 1'b1;
            nid_nxt             = (nid_r + 1'b1 == ID_NONE) ? ID_FIRST : nid_r + 1'b1;
          end
        end
        REQ_CANCEL: begin
          if (cur_active && id_match) begin
            active_nxt[ev_idx] = 1'b0;
            armed_nxt[ev_idx]  = 1'b0;
          end
        end
        REQ_PAUSE: begin
          if (cur_active && id_match) begin
            active_nxt[ev_idx] = 1'b0;
          end
        end
        REQ_RESUME: begin
          if (!cur_active && id_match) begin
            active_nxt[ev_idx] = 1'b1;
            we_start           = 1'b1;
          end
        end
        REQ_TICK: begin
          if (cur_active && cur_armed && due) begin
            we_start = 1'b1;
            expire   = 1'b1;
            if (!cur_repeat) begin
              active_nxt[ev_idx] = 1'b0;
              armed_nxt[ev_idx]  = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register: an expiry during the scan, or the closing reply.
  always_comb begin
    out_valid_nxt = expire || cmd.reply;
    out_kind_nxt  = KIND_REPLY;
    out_id_nxt    = ID_NONE;
    out_last_nxt  = 1'b1;
    if (expire) begin
      out_kind_nxt = KIND_EXPIRY;
      out_id_nxt   = cur_ident;
      out_last_nxt = 1'b0;
    end else if (req_r == REQ_ADD) begin
      out_id_nxt = got_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_result_id   = out_id_r;
  assign out_last        = out_last_r;

endmodule

@@ src/multi_slot_timer_table.sv @@
`timescale 1ns / 1ps

// Table of SLOTS software timers (one-shot or periodic), driven by items
// that each carry the current millisecond time. An item is taken when start
// is high and busy is low. Every item, whatever its kind, walks the whole
// slot table one slot per cycle through the single read port of the slot
// memories, so busy stays high after the accepting edge through the reads
// of every slot, the evaluation of the last slot and the forming of the
// closing result. Results come out of a register, each on out_valid for
// exactly one cycle; the receiver cannot stall them, so it must take every
// result in the cycle it is shown. A tick gives one expiry result per fired
// slot, in slot order, then a closing result with last set; every other
// item gives just the closing result, which for an add carries the new id,
// or zero when no slot was free.

module multi_slot_timer_table #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_req_type,
  input  logic [mtt_pkg::TIME_W-1:0]    in_now_ms,
  input  logic [mtt_pkg::TIME_W-1:0]    in_interval_ms,
  input  logic                          in_repeat_mode,
  input  logic                          in_has_action,
  input  logic [mtt_pkg::ID_W-1:0]      in_timer_id,
  output logic                          out_valid,
  output logic                          out_result_kind,
  output logic [mtt_pkg::ID_W-1:0]      out_result_id,
  output logic                          out_last
);

  import mtt_pkg::*;

  // Slot index width; a one-slot table still gets a one-bit index.
  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  mtt_cmd_t      cmd;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] ev_idx;

  // The controller sequences the scan; the datapath holds the slot state,
  // evaluates one slot per cycle and drives the result register.
  mtt_ctrl #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .rd_idx (rd_idx),
    .ev_idx (ev_idx)
  );

  mtt_dpath #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .rd_idx          (rd_idx),
    .ev_idx          (ev_idx),
    .in_req_type     (in_req_type),
    .in_now_ms       (in_now_ms),
    .in_interval_ms  (in_interval_ms),
    .in_repeat_mode  (in_repeat_mode),
    .in_has_action   (in_has_action),
    .in_timer_id     (in_timer_id),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_result_id   (out_result_id),
    .out_last        (out_last)
  );

endmodule

@@ tb/multi_slot_timer_table_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the timer slot table.
//
// Items are offered on start/busy and taken at a rising edge with start high
// and busy low. The monitor sees each accepted item at that same edge. It runs
// the bench's own model of the slot table on the item and queues the results
// the block owes. Every cycle with out_valid high is matched against the
// oldest queued result, field by field.
//
// The stimulus runs in three parts:
//   - A short directed table. Where a reply is obvious (fresh ids after reset,
//     a full table, a tick with nothing armed, the fixed zero of cancel,
//     pause, resume and unknown requests) the table carries the expected
//     reply itself. Every other row is checked against the model.
//   - A short clean-up that cancels every timer still live.
//   - Random traffic in four idling phases, biased toward well-formed
//     add/tick/pause/resume/cancel sequences on live ids, with some noise.
module multi_slot_timer_table_tb;
  import mtt_pkg::*;

  localparam int unsigned SLOTS     = 16;
  localparam int unsigned RUN_LIMIT = 4_000_000;
  localparam int unsigned MAX_SHOWN = 30;

  // Request codes that the block does not define. It must still close them
  // with a plain zero reply.
  localparam logic [2:0] REQ_SPARE5 = 3'd5;
  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [ID_W-1:0]   ID_MAX   = '1;

  typedef struct packed {
    logic              kind;
    logic [ID_W-1:0]   id;
    logic              last;
  } timer_result_t;

  // One request as offered to the block. When pinned is set, the single
  // closing reply is typed into the row instead of taken from the model.
  typedef struct packed {
    logic [2:0]        req;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] ival;
    logic              rep;
    logic              act;
    logic [ID_W-1:0]   tid;
    logic              pinned;
    logic [ID_W-1:0]   pin_id;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [2:0]        in_req_type;
  logic [TIME_W-1:0] in_now_ms;
  logic [TIME_W-1:0] in_interval_ms;
  logic              in_repeat_mode;
  logic              in_has_action;
  logic [ID_W-1:0]   in_timer_id;
  logic              out_valid;
  logic              out_result_kind;
  logic [ID_W-1:0]   out_result_id;
  logic              out_last;

  // The typed reply of a directed row travels with the item's fields. It is
  // driven the same way, so the monitor sees it at the accepting edge.
  logic              reply_pinned;
  logic [ID_W-1:0]   pinned_id;

  // The bench's own copy of the slot table.
  logic              tm_running [SLOTS];
  logic              tm_has_cb  [SLOTS];
  logic              tm_periodic[SLOTS];
  logic [TIME_W-1:0] tm_period  [SLOTS];
  logic [TIME_W-1:0] tm_origin  [SLOTS];
  logic [ID_W-1:0]   tm_ident   [SLOTS];
  logic [ID_W-1:0]   ident_next;
  bit                ident_wrapped;

  timer_result_t     step_results[$];
  timer_result_t     awaited_results[$];
  stim_row_t         directed_rows[$];

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned requests_taken;
  int unsigned results_checked;
  int unsigned expiry_total;
  int unsigned directed_sent;
  int unsigned sweep_sent;
  int unsigned random_sent;
  logic [TIME_W-1:0] clock_ms;

  multi_slot_timer_table #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_now_ms      (in_now_ms),
    .in_interval_ms (in_interval_ms),
    .in_repeat_mode (in_repeat_mode),
    .in_has_action  (in_has_action),
    .in_timer_id    (in_timer_id),
    .out_valid      (out_valid),
    .out_result_kind(out_result_kind),
    .out_result_id  (out_result_id),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The run ends here if the block stops answering.
  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still owed", cycle_count,
             awaited_results.size());
    $display("status: fail");
    $finish;
  end

  function automatic timer_result_t make_result(input logic kind,
                                                input logic [ID_W-1:0] id,
                                                input logic last);
    timer_result_t r;
    r.kind = kind;
    r.id   = id;
    r.last = last;
    return r;
  endfunction

  function automatic stim_row_t row_of(input logic [2:0] req,
                                       input logic [TIME_W-1:0] now,
                                       input logic [TIME_W-1:0] ival,
                                       input logic rep, input logic act,
                                       input logic [ID_W-1:0] tid,
                                       input logic pinned,
                                       input logic [ID_W-1:0] pin_id);
    stim_row_t row;
    row.req    = req;
    row.now    = now;
    row.ival   = ival;
    row.rep    = rep;
    row.act    = act;
    row.tid    = tid;
    row.pinned = pinned;
    row.pin_id = pin_id;
    return row;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
  endtask

  task automatic reset_timer_table();
    for (int s = 0; s < SLOTS; s++) begin
      tm_running[s]  = 1'b0;
      tm_has_cb[s]   = 1'b0;
      tm_periodic[s] = 1'b0;
      tm_period[s]   = '0;
      tm_origin[s]   = '0;
      tm_ident[s]    = ID_NONE;
    end
    ident_next    = ID_FIRST;
    ident_wrapped = 1'b0;
  endtask

  // Applies one request to the table copy and leaves the results it causes,
  // in order, in step_results.
  task automatic step_timer_table(input stim_row_t row);
    logic [TIME_W-1:0] elapsed;
    logic [ID_W-1:0]   granted;
    bit                placed;
    step_results.delete();
    granted = ID_NONE;
    placed  = 1'b0;
    case (row.req)
      REQ_ADD: begin
        // First inactive slot wins. A paused slot is inactive, so it can be
        // taken over here.
        for (int s = 0; s < SLOTS; s++) begin
          if (!placed && !tm_running[s]) begin
            placed         = 1'b1;
            tm_running[s]  = 1'b1;
            tm_periodic[s] = row.rep;
            tm_period[s]   = row.ival;
            tm_origin[s]   = row.now;
            tm_has_cb[s]   = row.act;
            tm_ident[s]    = ident_next;
            granted        = ident_next;
            ident_next     = ident_next + 1'b1;
            if (ident_next == ID_NONE) begin
              ident_next    = ID_FIRST;
              ident_wrapped = 1'b1;
            end
          end
        end
      end
      REQ_CANCEL, REQ_PAUSE: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (tm_running[s] && tm_ident[s] == row.tid) begin
            tm_running[s] = 1'b0;
            if (row.req == REQ_CANCEL) begin
              tm_has_cb[s] = 1'b0;
            end
          end
        end
      end
      REQ_RESUME: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (!tm_running[s] && tm_ident[s] == row.tid) begin
            tm_running[s] = 1'b1;
            tm_origin[s]  = row.now;
          end
        end
      end
      REQ_TICK: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (tm_running[s] && tm_has_cb[s]) begin
            elapsed = row.now - tm_origin[s];
            if (elapsed >= tm_period[s]) begin
              tm_origin[s] = row.now;
              step_results.push_back(make_result(KIND_EXPIRY, tm_ident[s], 1'b0));
              expiry_total++;
              if (!tm_periodic[s]) begin
                tm_running[s] = 1'b0;
                tm_has_cb[s]  = 1'b0;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    step_results.push_back(make_result(KIND_REPLY, granted, 1'b1));
  endtask

  // Monitor. Outputs are sampled at the rising edge, before the block's
  // registers move. Results shown at this edge come from items taken at
  // earlier edges, so they are checked before the item taken here is queued.
  always @(posedge clk) begin : result_monitor
    timer_result_t want;
    stim_row_t     taken;
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1) begin
        results_checked++;
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0b id %0d last %0b",
                                    out_result_kind, out_result_id, out_last));
        end else begin
          want = awaited_results.pop_front();
          if (out_result_kind !== want.kind) begin
            report_mismatch($sformatf("result kind %0b, expected %0b",
                                      out_result_kind, want.kind));
          end
          if (out_result_id !== want.id) begin
            report_mismatch($sformatf("result id %0d, expected %0d",
                                      out_result_id, want.id));
          end
          if (out_last !== want.last) begin
            report_mismatch($sformatf("last flag %0b, expected %0b",
                                      out_last, want.last));
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        requests_taken++;
        taken = row_of(in_req_type, in_now_ms, in_interval_ms, in_repeat_mode,
                       in_has_action, in_timer_id, reply_pinned, pinned_id);
        step_timer_table(taken);
        if (reply_pinned) begin
          awaited_results.push_back(make_result(KIND_REPLY, pinned_id, 1'b1));
        end else begin
          foreach (step_results[k]) begin
            awaited_results.push_back(step_results[k]);
          end
        end
      end
    end
  end

  // Puts one item on the inputs and returns at the edge that takes it. The
  // start line is left high, so a following item can go out back to back.
  task automatic issue_request(input stim_row_t row);
    in_req_type    <= row.req;
    in_now_ms      <= row.now;
    in_interval_ms <= row.ival;
    in_repeat_mode <= row.rep;
    in_has_action  <= row.act;
    in_timer_id    <= row.tid;
    reply_pinned   <= row.pinned;
    pinned_id      <= row.pin_id;
    start          <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic hold_off(input int unsigned cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Idle gap after an item. It is sized so that the sender sits idle for
  // about pct cycles of a hundred against the block's walk of the slot
  // table. The spread is wide, so start comes back anywhere in that walk
  // or well after it.
  function automatic int unsigned draw_gap(input int unsigned pct);
    if (pct == 0) begin
      return 0;
    end
    return $urandom_range(0, 2 * pct * (SLOTS + 2) / (100 - pct));
  endfunction

  function automatic logic [TIME_W-1:0] draw_interval();
    int unsigned dice;
    dice = $urandom_range(99);
    if (dice < 10) return '0;
    if (dice < 70) return $urandom_range(1, 24);
    if (dice < 85) return $urandom_range(25, 200);
    if (dice < 93) return $urandom;
    return TIME_MAX;
  endfunction

  // Target ids for cancel, pause and resume. Most hit a slot's current id,
  // so sequences act on live timers. Some aim at id zero, which also
  // matches slots that were never used, and the rest are random.
  function automatic logic [ID_W-1:0] draw_target();
    int unsigned dice;
    dice = $urandom_range(99);
    if (dice < 75) return tm_ident[$urandom_range(SLOTS - 1)];
    if (dice < 85) return ID_NONE;
    return ID_W'($urandom_range(ID_MAX));
  endfunction

  // Random request. The clock moves forward a little for each item and
  // sometimes jumps. Ticks and adds dominate, so timers are set up and
  // expire in a steady stream.
  function automatic stim_row_t draw_request();
    int unsigned dice;
    logic [2:0]  spare;
    dice = $urandom_range(99);
    if ($urandom_range(19) == 0) begin
      clock_ms = clock_ms + $urandom;
    end else begin
      clock_ms = clock_ms + $urandom_range(0, 9);
    end
    if (dice < 8) begin
      return row_of(3'($urandom_range(REQ_SPARE7)), $urandom, $urandom,
                    1'($urandom_range(1)), 1'($urandom_range(1)),
                    ID_W'($urandom_range(ID_MAX)), 1'b0, ID_NONE);
    end
    if (dice < 13) begin
      spare = 3'($urandom_range(REQ_SPARE7, REQ_SPARE5));
      return row_of(spare, clock_ms, $urandom, 1'($urandom_range(1)),
                    1'($urandom_range(1)), draw_target(), 1'b0, ID_NONE);
    end
    if (dice < 40) begin
      return row_of(REQ_ADD, clock_ms, draw_interval(), 1'($urandom_range(1)),
                    ($urandom_range(9) < 8), ID_NONE, 1'b0, ID_NONE);
    end
    if (dice < 75) begin
      return row_of(REQ_TICK, clock_ms, '0, 1'b0, 1'b0, ID_NONE, 1'b0, ID_NONE);
    end
    if (dice < 83) begin
      return row_of(REQ_CANCEL, clock_ms, '0, 1'b0, 1'b0, draw_target(), 1'b0,
                    ID_NONE);
    end
    if (dice < 91) begin
      return row_of(REQ_PAUSE, clock_ms, '0, 1'b0, 1'b0, draw_target(), 1'b0,
                    ID_NONE);
    end
    return row_of(REQ_RESUME, clock_ms, '0, 1'b0, 1'b0, draw_target(), 1'b0,
                  ID_NONE);
  endfunction

  // Directed table. Slot numbers in the comments follow the table's own
  // history from reset.
  task automatic build_directed_rows();
    // Nothing is armed after reset, so a tick closes with a bare reply.
    directed_rows.push_back(row_of(REQ_TICK, '0, '0, 1'b0, 1'b0, ID_NONE,
                                   1'b1, ID_NONE));
    // No slot carries id 1 yet, so resume finds nothing.
    directed_rows.push_back(row_of(REQ_RESUME, 32'd7, '0, 1'b0, 1'b0, ID_FIRST,
                                   1'b1, ID_NONE));
    // Fresh ids count up from one. Slot 0 is a zero-interval one-shot.
    // Slot 1 repeats and starts just short of the clock wrap. Slot 2 has
    // the widest interval. Slot 3 has no action.
    directed_rows.push_back(row_of(REQ_ADD, '0, '0, 1'b0, 1'b1, ID_NONE,
                                   1'b1, 16'd1));
    directed_rows.push_back(row_of(REQ_ADD, 32'hFFFF_FFF0, 32'h20, 1'b1, 1'b1,
                                   ID_NONE, 1'b1, 16'd2));
    directed_rows.push_back(row_of(REQ_ADD, '0, TIME_MAX, 1'b1, 1'b1, ID_NONE,
                                   1'b1, 16'd3));
    directed_rows.push_back(row_of(REQ_ADD, 32'd3, 32'd5, 1'b0, 1'b0, ID_NONE,
                                   1'b1, 16'd4));
    // The zero interval fires at once. Slot 1 fires one millisecond later,
    // once its elapsed time has counted across the clock wrap.
    directed_rows.push_back(row_of(REQ_TICK, 32'h0F, '0, 1'b0, 1'b0, ID_NONE,
                                   1'b0, ID_NONE));
    directed_rows.push_back(row_of(REQ_TICK, 32'h10, '0, 1'b0, 1'b0, ID_NONE,
                                   1'b0, ID_NONE));
    // A paused timer stays silent. Resume restarts its time.
    directed_rows.push_back(row_of(REQ_PAUSE, 32'h11, '0, 1'b0, 1'b0, 16'd2,
                                   1'b1, ID_NONE));
    directed_rows.push_back(row_of(REQ_TICK, 32'h40, '0, 1'b0, 1'b0, ID_NONE,
                                   1'b0, ID_NONE));
    directed_rows.push_back(row_of(REQ_RESUME, 32'h40, '0, 1'b0, 1'b0, 16'd2,
                                   1'b1, ID_NONE));
    directed_rows.push_back(row_of(REQ_TICK, 32'h5F, '0, 1'b0, 1'b0, ID_NONE,
                                   1'b0, ID_NONE));
    directed_rows.push_back(row_of(REQ_TICK, 32'h60, '0, 1'b0, 1'b0, ID_NONE,
                                   1'b0, ID_NONE));
    // Pause slot 1 again. The second add below takes it over.
    directed_rows.push_back(row_of(REQ_PAUSE, 32'h61, '0, 1'b0, 1'b0, 16'd2,
                                   1'b1, ID_NONE));
    directed_rows.push_back(row_of(REQ_ADD, 32'h70, 32'd1, 1'b1, 1'b1, ID_NONE,
                                   1'b0, ID_NONE));
    directed_rows.push_back(row_of(REQ_ADD, 32'h70, '0, 1'b1, 1'b1, ID_NONE,
                                   1'b0, ID_NONE));
    // Resume of id zero wakes every slot that was never used. Those slots
    // are live but unarmed, so the table is now full and add is refused.
    directed_rows.push_back(row_of(REQ_RESUME, 32'h80, '0, 1'b0, 1'b0, ID_NONE,
                                   1'b1, ID_NONE));
    directed_rows.push_back(row_of(REQ_ADD, 32'h80, 32'd9, 1'b1, 1'b1, ID_NONE,
                                   1'b1, ID_NONE));
    // At the top of the clock range, slot 2 reaches its widest interval.
    directed_rows.push_back(row_of(REQ_TICK, TIME_MAX, '0, 1'b0, 1'b0, ID_NONE,
                                   1'b0, ID_NONE));
    // Cancel the woken slots, then cancel and resume slot 2. It comes back
    // live but disarmed.
    directed_rows.push_back(row_of(REQ_CANCEL, 32'h90, '0, 1'b0, 1'b0, ID_NONE,
                                   1'b1, ID_NONE));
    directed_rows.push_back(row_of(REQ_CANCEL, 32'h91, '0, 1'b0, 1'b0, 16'd3,
                                   1'b1, ID_NONE));
    directed_rows.push_back(row_of(REQ_RESUME, 32'h92, '0, 1'b0, 1'b0, 16'd3,
                                   1'b1, ID_NONE));
    // Undefined request codes, with every field at each extreme.
    directed_rows.push_back(row_of(REQ_SPARE5, TIME_MAX, TIME_MAX, 1'b1, 1'b1,
                                   ID_MAX, 1'b1, ID_NONE));
    directed_rows.push_back(row_of(REQ_SPARE7, 32'h93, 32'd4, 1'b0, 1'b1,
                                   16'd5, 1'b1, ID_NONE));
    directed_rows.push_back(row_of(REQ_SPARE6, '0, '0, 1'b0, 1'b0, ID_NONE,
                                   1'b1, ID_NONE));
    directed_rows.push_back(row_of(REQ_TICK, 32'h100, '0, 1'b0, 1'b0, ID_NONE,
                                   1'b0, ID_NONE));
  endtask

  initial begin : stimulus
    logic [ID_W-1:0] live_ids[$];
    int unsigned     idle_pct;
    int unsigned     phase;
    int unsigned     n;

    mismatch_count  = 0;
    requests_taken  = 0;
    results_checked = 0;
    expiry_total    = 0;
    directed_sent   = 0;
    sweep_sent      = 0;
    random_sent     = 0;
    reset_timer_table();

    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_req_type    <= REQ_TICK;
    in_now_ms      <= '0;
    in_interval_ms <= '0;
    in_repeat_mode <= 1'b0;
    in_has_action  <= 1'b0;
    in_timer_id    <= ID_NONE;
    reply_pinned   <= 1'b0;
    pinned_id      <= ID_NONE;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows go out back to back.
    build_directed_rows();
    foreach (directed_rows[r]) begin
      issue_request(directed_rows[r]);
      directed_sent++;
    end
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);

    // Clear every live slot, so the random part starts from an empty table.
    for (int s = 0; s < SLOTS; s++) begin
      if (tm_running[s]) begin
        live_ids.push_back(tm_ident[s]);
      end
    end
    clock_ms = 32'h1000;
    foreach (live_ids[k]) begin
      issue_request(row_of(REQ_CANCEL, clock_ms, '0, 1'b0, 1'b0, live_ids[k],
                           1'b1, ID_NONE));
      sweep_sent++;
    end

    // Random traffic. The clock starts just below its wrap point. The four
    // phases are: no idling, sender idle most of the time, a phase where the
    // receiver would stall (it cannot, so nothing idles), and light idling
    // by the sender.
    clock_ms = 32'hFFFF_FF00;
    n        = 0;
    while (n < 80) begin
      phase = (n / 20 < 3) ? n / 20 : 3;
      case (phase)
        1:       idle_pct = 74;
        3:       idle_pct = 21;
        default: idle_pct = 0;
      endcase
      issue_request(draw_request());
      random_sent++;
      n++;
      hold_off(draw_gap(idle_pct));
    end
    start <= 1'b0;

    // Drain, then give the block one more full walk to show anything extra.
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);

    $display("covered %0d requests: %0d directed, %0d clean-up cancels, %0d random",
             requests_taken, directed_sent, sweep_sent, random_sent);
    $display("checked %0d results including %0d timer expiries, id wrap reached: %0d",
             results_checked, expiry_total, ident_wrapped);
    if (awaited_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
